[hw/rtl/dqe_pkg.sv]
// dqe_pkg: shared types and constants of the double-ended queue engine.
// Used by the channel interfaces and the top level.
package dqe_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 4;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 5;
	localparam int CNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_ERASE_IDX  = 3'd4,
		OP_ERASE_VAL  = 3'd5,
		OP_SEARCH     = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE = 2'd0,
		ST_FAIL = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// position reported when nothing matched
	localparam logic signed [FIDX_W-1:0] FOUND_NONE = -5'sd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RD_FRONT,
		S_RD_BACK,
		S_DONE
	} state_t;

endpackage

[hw/rtl/dqe_if.sv]
// dqe_if: valid/ready channels carrying request and result words.
// Depends on dqe_pkg for field widths.
interface dqe_req_if;
	logic                        valid;
	logic                        ready;
	logic [dqe_pkg::OP_W-1:0]    op;
	logic [dqe_pkg::VAL_W-1:0]   value;
	logic [dqe_pkg::IDX_W-1:0]   index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface dqe_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [dqe_pkg::STAT_W-1:0]        status;
	logic signed [dqe_pkg::FIDX_W-1:0] found_index;
	logic [dqe_pkg::CNT_W-1:0]         count;
	logic [dqe_pkg::VAL_W-1:0]         front_value;
	logic [dqe_pkg::VAL_W-1:0]         back_value;
	logic                              is_empty;

	modport source (output valid, output status, output found_index, output count,
		output front_value, output back_value, output is_empty, input ready);
	modport sink   (input valid, input status, input found_index, input count,
		input front_value, input back_value, input is_empty, output ready);
endinterface

[hw/rtl/double_ended_queue_engine_unit.sv]
// double_ended_queue_engine_unit: bounded deque in a ring RAM, one result word per request.
// Push, pop, clear: EXEC, then reads of the front and back entries, then DONE; a new request
// is taken only once the result is loaded. Search / erase value scan one entry per cycle;
// erase shifts the tail one entry per cycle. All reads share the single read port of the
// ring RAM.
// Reset (arst_n low): empty queue, front slot 0, no result pending; RAM not cleared.
module double_ended_queue_engine_unit #(
	parameter int DEPTH      = dqe_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dqe_req_if.sink    req,
	dqe_rsp_if.source  rsp
);

	localparam int SW   = $clog2(DEPTH);       // slot address width
	localparam int CW   = $clog2(DEPTH + 1);   // count / position width
	localparam int CMPW = (CW > dqe_pkg::IDX_W) ? CW : dqe_pkg::IDX_W;

	// ring slot of a position counted from the front; base + pos stays below 2*DEPTH
	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
		input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(pos);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return SW'(sum);
	endfunction

	dqe_pkg::state_t state_q, state_d;

	// latched request
	dqe_pkg::op_t           op_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [dqe_pkg::IDX_W-1:0] idx_q;

	// queue control state
	logic [SW-1:0] front_q;
	logic [CW-1:0] cnt_q;

	// walk position, and the read issued for it in the previous cycle
	logic [CW-1:0] pos_q;
	logic          rv_s1;
	logic [CW-1:0] pos_s1;
	logic [SW-1:0] wslot_s1;

	// per-request results
	dqe_pkg::status_t                     status_q;
	logic signed [dqe_pkg::FIDX_W-1:0]    found_q;
	logic [DATA_WIDTH-1:0]                front_data_q;

	// output register
	logic                                 rsp_valid_q;
	dqe_pkg::status_t                     rsp_status_q;
	logic signed [dqe_pkg::FIDX_W-1:0]    rsp_found_q;
	logic [dqe_pkg::CNT_W-1:0]            rsp_count_q;
	logic [dqe_pkg::VAL_W-1:0]            rsp_front_q;
	logic [dqe_pkg::VAL_W-1:0]            rsp_back_q;
	logic                                 rsp_empty_q;

	// RAM port
	logic                  ram_we, ram_re;
	logic [SW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic req_fire;
	logic is_full, is_empty_now;
	logic [SW-1:0] front_dec, front_inc;
	logic [CW-1:0] pos_inc;
	logic [CW-1:0] back_pos;
	logic scan_match, scan_go, shift_go;
	logic idx_bad;
	logic out_free;

	assign req.ready    = (state_q == dqe_pkg::S_IDLE);
	assign req_fire     = req.valid && req.ready;
	assign is_full      = (cnt_q == CW'(DEPTH));
	assign is_empty_now = (cnt_q == '0);
	assign front_dec    = (front_q == '0) ? SW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc    = (front_q == SW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign pos_inc      = pos_q + 1'b1;
	assign back_pos     = is_empty_now ? '0 : cnt_q - 1'b1;
	assign idx_bad      = (CMPW'(idx_q) >= CMPW'(cnt_q));
	assign out_free     = !rsp_valid_q || rsp.ready;

	// scan compares the word read last cycle; stop issuing once it hits
	assign scan_match = rv_s1 && (ram_rdata == val_q);
	assign scan_go    = !scan_match && (pos_q < cnt_q);
	// shift copies entry pos+1 down to pos while pos+1 is live
	assign shift_go   = ((CW+1)'(pos_q) + 1'b1) < (CW+1)'(cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dqe_pkg::S_IDLE: begin
				if (req_fire) state_d = dqe_pkg::S_EXEC;
			end
			dqe_pkg::S_EXEC: begin
				if (op_q == dqe_pkg::OP_ERASE_IDX && !idx_bad) begin
					state_d = dqe_pkg::S_SHIFT;
				end else if (op_q inside {dqe_pkg::OP_ERASE_VAL, dqe_pkg::OP_SEARCH}) begin
					state_d = dqe_pkg::S_SCAN;
				end else begin
					state_d = dqe_pkg::S_RD_FRONT;
				end
			end
			dqe_pkg::S_SCAN: begin
				if (scan_match) begin
					state_d = (op_q == dqe_pkg::OP_ERASE_VAL) ? dqe_pkg::S_SHIFT
						: dqe_pkg::S_RD_FRONT;
				end else if (!rv_s1 && !scan_go) begin
					state_d = dqe_pkg::S_RD_FRONT;
				end
			end
			dqe_pkg::S_SHIFT: begin
				if (!shift_go) state_d = dqe_pkg::S_RD_FRONT;
			end
			dqe_pkg::S_RD_FRONT: state_d = dqe_pkg::S_RD_BACK;
			dqe_pkg::S_RD_BACK:  state_d = dqe_pkg::S_DONE;
			dqe_pkg::S_DONE: begin
				if (out_free) state_d = dqe_pkg::S_IDLE;
			end
			default: state_d = dqe_pkg::S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			dqe_pkg::S_EXEC: begin
				if (op_q == dqe_pkg::OP_PUSH_FRONT && !is_full) begin
					ram_we    = 1'b1;
					ram_waddr = front_dec;
				end else if (op_q == dqe_pkg::OP_PUSH_BACK && !is_full) begin
					ram_we    = 1'b1;
					ram_waddr = slot_of(front_q, cnt_q);
				end
			end
			dqe_pkg::S_SCAN: begin
				ram_re    = scan_go;
				ram_raddr = slot_of(front_q, pos_q);
			end
			dqe_pkg::S_SHIFT: begin
				ram_we    = rv_s1;
				ram_waddr = wslot_s1;
				ram_wdata = ram_rdata;
				ram_re    = shift_go;
				ram_raddr = slot_of(front_q, pos_inc);
			end
			dqe_pkg::S_RD_FRONT: begin
				ram_re    = 1'b1;
				ram_raddr = front_q;
			end
			dqe_pkg::S_RD_BACK: begin
				ram_re    = 1'b1;
				ram_raddr = slot_of(front_q, back_pos);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	dqe_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request latch and per-request results (payload, no reset)
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= dqe_pkg::op_t'(req.op);
			val_q <= DATA_WIDTH'(req.value);
			idx_q <= req.index;
		end
		pos_s1 <= pos_q;
		if (state_q == dqe_pkg::S_SHIFT) begin
			wslot_s1 <= slot_of(front_q, pos_q);
		end
		if (state_q == dqe_pkg::S_RD_BACK) begin
			front_data_q <= ram_rdata;
		end
		case (state_q)
			dqe_pkg::S_EXEC: begin
				found_q  <= dqe_pkg::FOUND_NONE;
				status_q <= dqe_pkg::ST_DONE;
				pos_q    <= '0;
				case (op_q)
					dqe_pkg::OP_PUSH_FRONT,
					dqe_pkg::OP_PUSH_BACK: begin
						if (is_full) status_q <= dqe_pkg::ST_FULL;
					end
					dqe_pkg::OP_POP_FRONT,
					dqe_pkg::OP_POP_BACK,
					dqe_pkg::OP_CLEAR: begin
						if (is_empty_now) status_q <= dqe_pkg::ST_FAIL;
					end
					dqe_pkg::OP_ERASE_IDX: begin
						if (idx_bad) status_q <= dqe_pkg::ST_FAIL;
						pos_q <= CW'(idx_q);
					end
					default: begin
						pos_q <= '0;
					end
				endcase
			end
			dqe_pkg::S_SCAN: begin
				if (scan_match) begin
					found_q <= dqe_pkg::FIDX_W'(pos_s1);
					pos_q   <= pos_s1;
				end else begin
					if (scan_go) pos_q <= pos_inc;
					if (!rv_s1 && !scan_go) status_q <= dqe_pkg::ST_FAIL;
				end
			end
			dqe_pkg::S_SHIFT: begin
				if (shift_go) pos_q <= pos_inc;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// queue pointers and the read-in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1 <= 1'b0;
			case (state_q)
				dqe_pkg::S_EXEC: begin
					case (op_q)
						dqe_pkg::OP_PUSH_FRONT: begin
							if (!is_full) begin
								front_q <= front_dec;
								cnt_q   <= cnt_q + 1'b1;
							end
						end
						dqe_pkg::OP_PUSH_BACK: begin
							if (!is_full) cnt_q <= cnt_q + 1'b1;
						end
						dqe_pkg::OP_POP_FRONT: begin
							if (!is_empty_now) begin
								front_q <= front_inc;
								cnt_q   <= cnt_q - 1'b1;
							end
						end
						dqe_pkg::OP_POP_BACK: begin
							if (!is_empty_now) cnt_q <= cnt_q - 1'b1;
						end
						dqe_pkg::OP_CLEAR: begin
							front_q <= '0;
							cnt_q   <= '0;
						end
						default: begin
							cnt_q <= cnt_q;
						end
					endcase
				end
				dqe_pkg::S_SCAN:  rv_s1 <= scan_go;
				dqe_pkg::S_SHIFT: begin
					rv_s1 <= shift_go;
					// last copy lands this cycle; the tail entry goes away
					if (!shift_go) cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					rv_s1 <= 1'b0;
				end
			endcase
		end
	end

	// result register: loads in DONE, holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == dqe_pkg::S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dqe_pkg::S_DONE && out_free) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_count_q  <= dqe_pkg::CNT_W'(cnt_q);
			rsp_empty_q  <= is_empty_now;
			// read data still holds the back entry fetched in RD_BACK
			rsp_front_q  <= is_empty_now ? '0 : dqe_pkg::VAL_W'(front_data_q);
			rsp_back_q   <= is_empty_now ? '0 : dqe_pkg::VAL_W'(ram_rdata);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_index = rsp_found_q;
	assign rsp.count       = rsp_count_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.back_value  = rsp_back_q;
	assign rsp.is_empty    = rsp_empty_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= SW'(DEPTH - 1))
		else $error("front slot out of range");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == dqe_pkg::S_EXEC)
		else $error("accepted request not executed");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == dqe_pkg::S_DONE))
		else $error("result raised outside DONE");

	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == dqe_pkg::S_SHIFT) |-> $past(ram_re))
		else $error("shift write without a preceding read");

endmodule

[hw/rtl/dqe_ram.sv]
// dqe_ram: generic simple dual-port RAM, one write and one read port.
// Read data is registered and holds while no read is issued. No dependencies.
module dqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
